[sv/cell_luminance_wavelet_smoother_defines.svh]
// assertion macros for the luminance smoother checker
// no dependencies; included by the checker file
`ifndef CELL_LUMINANCE_WAVELET_SMOOTHER_DEFINES_SVH
`define CELL_LUMINANCE_WAVELET_SMOOTHER_DEFINES_SVH

// same-cycle implication under active-low reset
`define CLWS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("clws check failed");

// next-cycle implication under active-low reset
`define CLWS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("clws check failed");

`endif

[sv/clws_pkg.sv]
// shared types and constants for the luminance wavelet smoother
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package clws_pkg;
  localparam int unsigned MAX_CELLS_DEF   = 8192;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned CFG_DATA_W      = 20;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CELL_IDX_W      = 13;

  // threshold factors, q0.16
  localparam logic [15:0] K_L1_8     = 16'd16683;
  localparam logic [15:0] K_L2_8     = 16'd10486;
  localparam logic [15:0] K_L3_8     = 16'd3707;
  localparam logic [15:0] K_FINE_4   = 16'd13902;
  localparam logic [15:0] K_COARSE_4 = 16'd5243;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WAV_EN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_READ,
    ST_COEF,
    ST_SHRINK,
    ST_MULT,
    ST_LEVEL,
    ST_DONE
  } state_e;
endpackage
`default_nettype wire

[sv/cell_luminance_wavelet_smoother.sv]
// top level of the per-cell luminance smoother with haar shrinkage
// depends on clws_pkg
`timescale 1ns / 1ps
`default_nettype none
// channel   | direction | tdata (low bit up)            | tuser
// s_axis    | in        | cell_index[12:0], sample      | -
// m_axis    | out       | smoothed_level (signed)       | bad_index
// cfg       | in        | write enable, index, data     | -
// paths: bad index, first sample of a cell, plain ema, 4-point pass and
//   8-point pass; the passes read the cell history serially from the ring
//   memory before the shrinkage and the ema step
// reset: state memory is cleared cell by cell after reset, no item taken
// stalls: a held result blocks only the hand-off of the next one
module cell_luminance_wavelet_smoother #(
  parameter int unsigned MAX_CELLS   = clws_pkg::MAX_CELLS_DEF,
  parameter int unsigned SAMPLE_BITS = clws_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // cell_index, sample
  input  wire logic [((clws_pkg::CELL_IDX_W+SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                                               s_axis_tvalid,
  output logic                                                    s_axis_tready,
  // smoothed_level
  output logic [((SAMPLE_BITS+2+7)/8)*8-1:0] m_axis_tdata,
  // bad_index
  output logic                               m_axis_tuser,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic                          cfg_we_i,
  input  wire logic [clws_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [clws_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned LVL_W  = SB + 2;
  localparam int unsigned AW     = SB + 8;
  localparam int unsigned PW     = AW + 18;
  localparam int unsigned SH     = 32 - SB;
  localparam int unsigned CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned HA_W   = CELL_W + 3;
  localparam int unsigned ST_W   = 3 + 4 + 1 + LVL_W;
  localparam int unsigned OUT_TW = ((LVL_W + 7) / 8) * 8;

  // configuration registers
  logic [16:0] gain_q;
  logic        wav_en_q;
  logic [3:0]  window_q;
  logic [19:0] strength_q;
  logic [13:0] active_q;

  clws_pkg::state_e state_q, state_d;

  // memories: history ring per cell, and per-cell pointer/fill/start/level
  logic [SB-1:0]   hist_mem [MAX_CELLS*8];
  logic [ST_W-1:0] st_mem   [MAX_CELLS];
  logic [SB-1:0]   hist_rd_q;
  logic [ST_W-1:0] st_rd_q;

  logic            hist_we;
  logic [HA_W-1:0] hist_waddr, hist_raddr;
  logic            st_we;
  logic [CELL_W-1:0] st_waddr;
  logic [ST_W-1:0]   st_wdata;

  logic [CELL_W-1:0] clr_q;
  logic [CELL_W-1:0] cell_q;
  logic [SB-1:0]     sample_q;
  logic              bad_q;
  logic [2:0]        newwp_q, start_q, nr_q, cnt_q;
  logic [3:0]        newfill_q;
  logic              m8_q;
  logic [SB-1:0]     s_q [8];
  logic signed [AW-1:0] thr_q [3];
  logic signed [AW-1:0] sum_q, c0_q, c1_q, c2_q, obs_q, old_q;
  logic signed [PW-1:0] prod_q;
  logic signed [LVL_W-1:0] level_q;

  logic              out_valid_q, out_bad_q;
  logic [LVL_W-1:0]  out_level_q;

  // input fields
  logic [clws_pkg::CELL_IDX_W-1:0] in_idx;
  logic [SB-1:0]                   in_sample;
  logic [16:0]                     idx_ext;
  logic                            in_bad, in_acc, out_load;
  assign in_idx    = s_axis_tdata[clws_pkg::CELL_IDX_W-1:0];
  assign in_sample = s_axis_tdata[clws_pkg::CELL_IDX_W +: SB];
  assign idx_ext   = 17'(in_idx);
  assign in_bad    = (idx_ext >= 17'(active_q)) || (idx_ext >= 17'(MAX_CELLS));
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state_q == clws_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);

  // decoded fields of the stored cell word
  logic [2:0] rd_wp;
  logic [3:0] rd_fill;
  logic       rd_started;
  logic [LVL_W-1:0] rd_level;
  assign {rd_wp, rd_fill, rd_started, rd_level} = st_rd_q;

  logic [2:0] dec_newwp;
  logic [3:0] dec_newfill;
  logic       dec_m8, dec_m4;
  assign dec_newwp   = rd_wp + 3'd1;
  assign dec_newfill = (rd_fill < 4'd8) ? rd_fill + 4'd1 : 4'd8;
  assign dec_m8      = wav_en_q && (window_q >= 4'd8) && (dec_newfill >= 4'd8);
  assign dec_m4      = wav_en_q && (window_q >= 4'd4) && !dec_m8 && (dec_newfill >= 4'd4);

  function automatic logic signed [AW-1:0] ext(input logic [SB-1:0] v);
    ext = $signed({{(AW-SB){1'b0}}, v});
  endfunction

  function automatic logic signed [AW-1:0] shrink(input logic signed [AW-1:0] c,
                                                  input logic signed [AW-1:0] t);
    if (c > t) shrink = c - t;
    else if (c < -t) shrink = c + t;
    else shrink = '0;
  endfunction

  // threshold: strength times factor, rounded to sample units
  logic [15:0] kmux;
  logic [36:0] tprod, tround;
  always_comb begin
    case (cnt_q)
      3'd0:    kmux = m8_q ? clws_pkg::K_L3_8 : clws_pkg::K_COARSE_4;
      3'd1:    kmux = m8_q ? clws_pkg::K_L2_8 : clws_pkg::K_FINE_4;
      default: kmux = clws_pkg::K_L1_8;
    endcase
  end
  assign tprod  = 37'(strength_q) * 37'(kmux);
  assign tround = (tprod + (37'(1) << (SH - 1))) >> SH;

  // shrinkage and reconstruction of the newest sample
  logic signed [AW-1:0] x_val, obs_val;
  always_comb begin
    x_val = sum_q - shrink(c0_q, thr_q[0]) - (shrink(c1_q, thr_q[1]) <<< 1);
    if (m8_q) begin
      x_val   = x_val - (shrink(c2_q, thr_q[2]) <<< 2);
      obs_val = (x_val + AW'(4)) >>> 3;
    end else begin
      obs_val = (x_val + AW'(2)) >>> 2;
    end
  end

  // ema rounding and clamp
  logic signed [PW-1:0] prod_rnd;
  logic signed [AW-1:0] lvl_raw;
  logic signed [AW-1:0] lvl_max, lvl_min;
  logic [16:0]          gain_eff;
  assign gain_eff = (gain_q > 17'd65536) ? 17'd65536 : gain_q;
  assign prod_rnd = (prod_q + (PW'(1) <<< 15)) >>> 16;
  assign lvl_raw  = old_q + prod_rnd[AW-1:0];
  assign lvl_max  = (AW'(1) <<< (SB + 1)) - AW'(1);
  assign lvl_min  = -(AW'(1) <<< (SB + 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clws_pkg::ST_CLEAR:  if (clr_q == CELL_W'(MAX_CELLS - 1)) state_d = clws_pkg::ST_IDLE;
      clws_pkg::ST_IDLE:   if (in_acc) state_d = in_bad ? clws_pkg::ST_DONE
                                                        : clws_pkg::ST_LOOKUP;
      clws_pkg::ST_LOOKUP: state_d = clws_pkg::ST_DECIDE;
      clws_pkg::ST_DECIDE: begin
        if (!rd_started) state_d = clws_pkg::ST_DONE;
        else if (dec_m8 || dec_m4) state_d = clws_pkg::ST_READ;
        else state_d = clws_pkg::ST_MULT;
      end
      clws_pkg::ST_READ:   if (cnt_q == nr_q) state_d = clws_pkg::ST_COEF;
      clws_pkg::ST_COEF:   state_d = clws_pkg::ST_SHRINK;
      clws_pkg::ST_SHRINK: state_d = clws_pkg::ST_MULT;
      clws_pkg::ST_MULT:   state_d = clws_pkg::ST_LEVEL;
      clws_pkg::ST_LEVEL:  state_d = clws_pkg::ST_DONE;
      clws_pkg::ST_DONE:   if (out_load) state_d = clws_pkg::ST_IDLE;
      default:             state_d = clws_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and memory ports
  always_comb begin
    s_axis_tready = 1'b0;
    hist_we       = 1'b0;
    st_we         = 1'b0;
    st_waddr      = cell_q;
    st_wdata      = {newwp_q, newfill_q, 1'b1, level_q};
    hist_waddr    = {cell_q, rd_wp};
    hist_raddr    = {cell_q, start_q + cnt_q};
    unique case (state_q)
      clws_pkg::ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = '0;
      end
      clws_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      clws_pkg::ST_DECIDE: hist_we = 1'b1;
      clws_pkg::ST_DONE:   st_we = out_load && !bad_q;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (hist_we) hist_mem[hist_waddr] <= sample_q;
    hist_rd_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    st_rd_q <= st_mem[cell_q];
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clws_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= 17'd32768;
      wav_en_q    <= 1'b0;
      window_q    <= 4'd8;
      strength_q  <= '0;
      active_q    <= 14'(MAX_CELLS);
    end else begin
      state_q <= state_d;
      if (state_q == clws_pkg::ST_CLEAR) clr_q <= clr_q + CELL_W'(1);
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          clws_pkg::REG_GAIN:     gain_q     <= cfg_data_i[16:0];
          clws_pkg::REG_WAV_EN:   wav_en_q   <= cfg_data_i[0];
          clws_pkg::REG_WINDOW:   window_q   <= cfg_data_i[3:0];
          clws_pkg::REG_STRENGTH: strength_q <= cfg_data_i;
          clws_pkg::REG_ACTIVE:   active_q   <= cfg_data_i[13:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      clws_pkg::ST_IDLE: begin
        cell_q   <= idx_ext[CELL_W-1:0];
        sample_q <= in_sample;
        bad_q    <= in_bad;
        level_q  <= '0;
      end
      clws_pkg::ST_DECIDE: begin
        newwp_q   <= dec_newwp;
        newfill_q <= dec_newfill;
        m8_q      <= dec_m8;
        start_q   <= dec_m8 ? dec_newwp : dec_newwp + 3'd4;
        nr_q      <= dec_m8 ? 3'd7 : 3'd3;
        cnt_q     <= '0;
        old_q     <= $signed({{(AW-LVL_W){rd_level[LVL_W-1]}}, rd_level});
        obs_q     <= ext(sample_q);
        level_q   <= $signed(LVL_W'(sample_q));
        if (dec_m8) s_q[7] <= sample_q;
        else s_q[3] <= sample_q;
      end
      clws_pkg::ST_READ: begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q != 3'd0) s_q[cnt_q - 3'd1] <= hist_rd_q;
        if (cnt_q < 3'd3) thr_q[cnt_q[1:0]] <= $signed(tround[AW-1:0]);
      end
      clws_pkg::ST_COEF: begin
        if (m8_q) begin
          sum_q <= ext(s_q[0]) + ext(s_q[1]) + ext(s_q[2]) + ext(s_q[3])
                 + ext(s_q[4]) + ext(s_q[5]) + ext(s_q[6]) + ext(s_q[7]);
          c0_q  <= ext(s_q[0]) + ext(s_q[1]) + ext(s_q[2]) + ext(s_q[3])
                 - ext(s_q[4]) - ext(s_q[5]) - ext(s_q[6]) - ext(s_q[7]);
          c1_q  <= ext(s_q[4]) + ext(s_q[5]) - ext(s_q[6]) - ext(s_q[7]);
          c2_q  <= ext(s_q[6]) - ext(s_q[7]);
        end else begin
          sum_q <= ext(s_q[0]) + ext(s_q[1]) + ext(s_q[2]) + ext(s_q[3]);
          c0_q  <= ext(s_q[0]) + ext(s_q[1]) - ext(s_q[2]) - ext(s_q[3]);
          c1_q  <= ext(s_q[2]) - ext(s_q[3]);
          c2_q  <= '0;
        end
      end
      clws_pkg::ST_SHRINK: obs_q <= obs_val;
      clws_pkg::ST_MULT: prod_q <= PW'($signed({1'b0, gain_eff})) * PW'(obs_q - old_q);
      clws_pkg::ST_LEVEL: begin
        if (lvl_raw > lvl_max) level_q <= lvl_max[LVL_W-1:0];
        else if (lvl_raw < lvl_min) level_q <= lvl_min[LVL_W-1:0];
        else level_q <= lvl_raw[LVL_W-1:0];
      end
      default: ;
    endcase
    if (out_load) begin
      out_level_q <= level_q;
      out_bad_q   <= bad_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'(out_level_q);
  assign m_axis_tuser  = out_bad_q;
endmodule
`default_nettype wire

[sv/clws_checker.sv]
// port-level checks for the luminance smoother, bound to the top level
// depends on clws_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "cell_luminance_wavelet_smoother_defines.svh"
module clws_checker #(
  parameter int unsigned SAMPLE_BITS = clws_pkg::SAMPLE_BITS_DEF
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic [((SAMPLE_BITS+2+7)/8)*8-1:0] m_axis_tdata,
  input wire logic m_axis_tuser,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready
);
  `CLWS_ASSERT_NEXT(out_hold_a, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CLWS_ASSERT_NEXT(out_stable_a, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `CLWS_ASSERT_NOW(bad_zero_a, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `CLWS_ASSERT_NEXT(one_item_a, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind cell_luminance_wavelet_smoother clws_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_clws_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
`default_nettype wire

[tb/cell_luminance_wavelet_smoother_tb.sv]
// self-checking bench for the per-cell luminance wavelet smoother
// depends on clws_pkg and the cell_luminance_wavelet_smoother rtl
`timescale 1ns / 1ps

// keeps per-cell smoother state and the queue of expected result items
class level_scoreboard;
  logic [15:0] hist [int];
  logic [2:0]  wptr [int];
  int          fill [int];
  bit          begun [int];
  longint      level [int];
  longint      gain, wav_en, window, strength, active;
  longint      exp_level [$];
  bit          exp_bad [$];
  int          errors;

  function void clear();
    hist.delete(); wptr.delete(); fill.delete(); begun.delete(); level.delete();
    gain = 32768; wav_en = 0; window = 8; strength = 0; active = 8192;
    exp_level.delete(); exp_bad.delete(); errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, longint v);
    case (idx)
      clws_pkg::REG_GAIN:     gain = v & 'h1FFFF;
      clws_pkg::REG_WAV_EN:   wav_en = v & 1;
      clws_pkg::REG_WINDOW:   window = v & 'hF;
      clws_pkg::REG_STRENGTH: strength = v & 'hFFFFF;
      clws_pkg::REG_ACTIVE:   active = v & 'h3FFF;
      default: ;
    endcase
  endfunction

  // half-up rounding right shift for signed values
  function longint rnd_shift(longint x, int sh);
    return (x + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function longint thr(longint k);
    return (strength * k + 32768) >> 16;
  endfunction

  function longint shrink(longint c, longint t);
    if (c > t) return c - t;
    if (c < -t) return c + t;
    return 0;
  endfunction

  // back = 0 is the newest sample
  function longint newest(int cidx, int back);
    return hist[cidx * 8 + ((wptr[cidx] + 7 - back) & 7)];
  endfunction

  function void note_item(int cidx, longint smp);
    longint s [8];
    longint obs, g, lv, lo, hi, x;
    if (cidx >= active) begin
      exp_level.push_back(0); exp_bad.push_back(1);
      return;
    end
    if (!wptr.exists(cidx)) begin
      wptr[cidx] = 0; fill[cidx] = 0; begun[cidx] = 0; level[cidx] = 0;
    end
    hist[cidx * 8 + wptr[cidx]] = smp[15:0];
    wptr[cidx] = wptr[cidx] + 1;
    if (fill[cidx] < 8) fill[cidx]++;
    if (!begun[cidx]) begin
      begun[cidx] = 1;
      lv = smp;
    end else begin
      obs = smp;
      if (wav_en != 0 && window >= 8 && fill[cidx] >= 8) begin
        for (int i = 0; i < 8; i++) s[i] = newest(cidx, 7 - i);
        lo = s[0] + s[1] + s[2] + s[3];
        hi = s[4] + s[5] + s[6] + s[7];
        x = lo + hi - shrink(lo - hi, thr(clws_pkg::K_L3_8))
            - 2 * shrink(s[4] + s[5] - s[6] - s[7], thr(clws_pkg::K_L2_8))
            - 4 * shrink(s[6] - s[7], thr(clws_pkg::K_L1_8));
        obs = rnd_shift(x, 3);
      end else if (wav_en != 0 && window >= 4 && fill[cidx] >= 4) begin
        for (int i = 0; i < 4; i++) s[i] = newest(cidx, 3 - i);
        x = s[0] + s[1] + s[2] + s[3]
            - shrink(s[0] + s[1] - s[2] - s[3], thr(clws_pkg::K_COARSE_4))
            - 2 * shrink(s[2] - s[3], thr(clws_pkg::K_FINE_4));
        obs = rnd_shift(x, 2);
      end
      g = (gain > 65536) ? 65536 : gain;
      lv = level[cidx] + rnd_shift(g * (obs - level[cidx]), 16);
      if (lv > 131071) lv = 131071;
      if (lv < -131072) lv = -131072;
    end
    level[cidx] = lv;
    exp_level.push_back(lv); exp_bad.push_back(0);
  endfunction

  function void check_result(logic [17:0] got_level, logic got_bad);
    longint el;
    bit eb;
    if (exp_level.size() == 0) begin
      $display("%0t: unexpected item level=%0d bad=%0b", $time, $signed(got_level), got_bad);
      errors++;
      return;
    end
    el = exp_level.pop_front();
    eb = exp_bad.pop_front();
    if (longint'($signed(got_level)) != el) begin
      $display("%0t: level mismatch expected %0d actual %0d", $time, el, $signed(got_level));
      errors++;
    end
    if (got_bad != eb) begin
      $display("%0t: bad_index mismatch expected %0b actual %0b", $time, eb, got_bad);
      errors++;
    end
  endfunction
endclass

module cell_luminance_wavelet_smoother_tb;
  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic        cfg_we_i = 0;
  logic [2:0]  cfg_idx_i = '0;
  logic [19:0] cfg_data_i = '0;

  level_scoreboard sb;
  longint cycles = 0;
  int     sent = 0;
  int     recvd = 0;
  bit     sink_on = 0;

  always #5 clk_i = ~clk_i;

  cell_luminance_wavelet_smoother dut (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // runaway guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // result side: sample at the rising edge, random stalls drawn per item
  initial begin
    int stall;
    forever begin
      @(negedge clk_i);
      if (sink_on) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        repeat (stall) @(negedge clk_i);
        m_axis_tready <= 1;
        do @(posedge clk_i); while (!m_axis_tvalid);
        sb.check_result(m_axis_tdata[17:0], m_axis_tuser);
        recvd++;
        @(negedge clk_i);
        m_axis_tready <= 0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [19:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, v);
  endtask

  // one input item with a random lead gap; valid drops only over a gap
  task automatic send_item(int cidx, int smp, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata <= {3'b0, smp[15:0], cidx[12:0]};
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(cidx, smp);
    sent++;
    @(negedge clk_i);
  endtask

  // drain everything, then let the block go quiet before a register write
  task automatic wait_idle();
    s_axis_tvalid <= 0;
    while (sb.exp_level.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // mostly a handful of cells so histories fill and the passes engage
  task automatic random_phase(int n);
    int cidx, smp, mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) cidx = $urandom_range(0, 7);
      else if (mode < 9) cidx = $urandom_range(0, 8191);
      else cidx = 8191 - $urandom_range(0, 3);
      case ($urandom_range(0, 3))
        0: smp = $urandom_range(0, 65535);
        1: smp = $urandom_range(0, 1) ? 65535 : 0;
        default: smp = 30000 + $urandom_range(0, 2000);
      endcase
      send_item(cidx, smp, $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    sink_on = 1;

    // directed: reset settings, extreme fields, first-sample and plain ema
    send_item(0, 0, 0);
    send_item(0, 65535, 0);
    send_item(8191, 65535, 0);
    send_item(5461, 21845, 1);
    send_item(2730, 43690, 1);
    wait_idle();
    // bad index, gain above one, zero gain
    write_reg(clws_pkg::REG_ACTIVE, 20'd16);
    write_reg(clws_pkg::REG_GAIN, 20'h1FFFF);
    send_item(16, 1234, 0);
    send_item(8191, 1, 0);
    send_item(0, 777, 0);
    wait_idle();
    write_reg(clws_pkg::REG_GAIN, 20'd0);
    send_item(0, 65535, 0);
    wait_idle();
    // short history fallback, 4-point pass and full 8-point pass, max strength
    write_reg(clws_pkg::REG_GAIN, 20'd65536);
    write_reg(clws_pkg::REG_WAV_EN, 20'd1);
    write_reg(clws_pkg::REG_WINDOW, 20'd8);
    write_reg(clws_pkg::REG_STRENGTH, 20'hFFFFF);
    for (int i = 0; i < 9; i++) send_item(3, (i & 1) ? 65535 : 0, 0);
    wait_idle();
    write_reg(clws_pkg::REG_ACTIVE, 20'd0);
    send_item(0, 5, 0);
    wait_idle();

    // random phases across settings, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(clws_pkg::REG_ACTIVE, ph == 0 ? 20'd8192 : ph == 1 ? 20'd1 : ph < 5 ? 20'd6
                : 20'($urandom_range(4, 8192)));
      write_reg(clws_pkg::REG_GAIN, ph == 2 ? 20'd0 : ph == 3 ? 20'd65536
                : 20'($urandom_range(0, 131071)));
      write_reg(clws_pkg::REG_WAV_EN, 20'(ph % 4 != 0));
      write_reg(clws_pkg::REG_WINDOW, 20'(ph == 4 ? 15 : ph == 5 ? 0 : $urandom_range(0, 15)));
      write_reg(clws_pkg::REG_STRENGTH, ph == 6 ? 20'hFFFFF : ph == 7 ? 20'd0
                : 20'($urandom_range(0, 1048575) >> $urandom_range(0, 8)));
      random_phase(120);
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("run covered %0d items in and %0d results out over ten settings,", sent, recvd);
      $display("with bad cells, gain extremes and both shrinkage windows");
      $display("status: pass");
    end else begin
      $display("%0d mismatches over %0d items", sb.errors, sent);
      $display("status: fail");
    end
    $finish;
  end
endmodule
